FILE: rtl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants for the sphere / frustum culling core.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int COORD_W            = 32;
    localparam int MASK_W             = 32;
    localparam int CNT_W              = 4;
    localparam int SLOT_W             = 3;
    localparam int FRAC_W             = 16;
    localparam int PLANES_PER_FRUSTUM = 6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEST = 1'b1;

    localparam logic [SLOT_W-1:0] LAST_PLANE = SLOT_W'(PLANES_PER_FRUSTUM - 1);

    typedef struct packed {
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [COORD_W-1:0] nz;
        logic [COORD_W-1:0] d;
    } t_plane;

    typedef struct packed {
        logic valid;
        logic last;
    } t_eval_ctl;

endpackage

FILE: rtl/cfc_if.sv
// ----------------------------------------------------------------------------
// cfc channel interfaces
// Valid/ready channels for test and load items, result items and the
// active frustum count register.
// ----------------------------------------------------------------------------
interface cfc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [cfc_pkg::SLOT_W-1:0]  frustum_slot;
    logic [cfc_pkg::SLOT_W-1:0]  plane_slot;
    logic signed [cfc_pkg::COORD_W-1:0] coord_x;
    logic signed [cfc_pkg::COORD_W-1:0] coord_y;
    logic signed [cfc_pkg::COORD_W-1:0] coord_z;
    logic signed [cfc_pkg::COORD_W-1:0] coord_w;
    logic [cfc_pkg::MASK_W-1:0]  prior_mask;

    modport source (output valid, mode, frustum_slot, plane_slot, coord_x, coord_y,
                    coord_z, coord_w, prior_mask, input ready);
    modport sink   (input valid, mode, frustum_slot, plane_slot, coord_x, coord_y,
                    coord_z, coord_w, prior_mask, output ready);
endinterface

interface cfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [cfc_pkg::MASK_W-1:0] new_mask;

    modport source (output valid, new_mask, input ready);
    modport sink   (input valid, new_mask, output ready);
endinterface

interface cfc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cfc_pkg::CNT_W-1:0] active_frustum_count;

    modport source (output valid, active_frustum_count, input ready);
    modport sink   (input valid, active_frustum_count, output ready);
endinterface

FILE: rtl/cfc_plane_mem.sv
// ----------------------------------------------------------------------------
// cfc_plane_mem
// Plane table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfc_plane_mem #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  cfc_pkg::t_plane       i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output cfc_pkg::t_plane       o_rdata
);

    cfc_pkg::t_plane r_mem [DEPTH];
    cfc_pkg::t_plane r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cfc_plane_eval.sv
// ----------------------------------------------------------------------------
// cfc_plane_eval
// Three-stage plane test: products, partial sums, sign of the exact sum
// dot(n,c) + (d + r) * 2^16.
// ----------------------------------------------------------------------------
module cfc_plane_eval #(
    parameter int FW = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cfc_pkg::t_eval_ctl                i_ctl,
    input  logic [FW-1:0]                     i_fk,
    input  cfc_pkg::t_plane                   i_plane,
    input  logic signed [cfc_pkg::COORD_W-1:0] i_cx,
    input  logic signed [cfc_pkg::COORD_W-1:0] i_cy,
    input  logic signed [cfc_pkg::COORD_W-1:0] i_cz,
    input  logic signed [cfc_pkg::COORD_W-1:0] i_rad,
    output cfc_pkg::t_eval_ctl                o_ctl,
    output logic [FW-1:0]                     o_fk,
    output logic                              o_cull
);

    localparam int PW = 2 * cfc_pkg::COORD_W;

    cfc_pkg::t_eval_ctl r_ctl1, r_ctl2, r_ctl3;
    logic [FW-1:0]      r_fk1, r_fk2, r_fk3;

    logic signed [PW-1:0]                r_px, r_py, r_pz;
    logic signed [cfc_pkg::COORD_W:0]    r_dr;
    logic signed [PW:0]                  r_sa, r_sb;
    logic                                r_cull;

    logic signed [PW:0]   dr_sh;
    logic signed [PW+1:0] total;

    assign dr_sh = $signed({{(PW - cfc_pkg::COORD_W - cfc_pkg::FRAC_W){r_dr[cfc_pkg::COORD_W]}},
                            r_dr, {cfc_pkg::FRAC_W{1'b0}}});
    assign total = $signed({r_sa[PW], r_sa}) + $signed({r_sb[PW], r_sb});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fk1 <= i_fk;
        r_fk2 <= r_fk1;
        r_fk3 <= r_fk2;
        r_px  <= $signed(i_plane.nx) * i_cx;
        r_py  <= $signed(i_plane.ny) * i_cy;
        r_pz  <= $signed(i_plane.nz) * i_cz;
        r_dr  <= $signed({i_plane.d[cfc_pkg::COORD_W-1], i_plane.d})
               + $signed({i_rad[cfc_pkg::COORD_W-1], i_rad});
        r_sa  <= $signed({r_px[PW-1], r_px}) + $signed({r_py[PW-1], r_py});
        r_sb  <= $signed({r_pz[PW-1], r_pz}) + dr_sh;
        r_cull <= total[PW+1];
    end

    assign o_ctl  = r_ctl3;
    assign o_fk   = r_fk3;
    assign o_cull = r_cull;

endmodule

FILE: rtl/sphere_frustum_cull_core.sv
// ----------------------------------------------------------------------------
// sphere_frustum_cull_core
// Bounding sphere test against six-plane frustums held in an on-chip table.
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one plane entry and returns its prior_mask
// through the S_DONE state and the output register. A test item (mode 1)
// reads one plane entry per cycle from the plane table (one write port, one
// read port) and feeds a three-stage multiply/add pipeline; N, the number of
// frustums it tests, is the active frustum count limited to MAX_FRUSTA, and
// with N = 0 the result goes straight through S_DONE. One item is in work at
// a time, and the next is accepted as soon as its result sits in the output
// register. Plane entries are undefined until loaded.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_core #(
    parameter int MAX_FRUSTA = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfc_in_if.sink     i_in,
    cfc_out_if.source  o_out,
    cfc_cfg_if.sink    i_cfg
);

    localparam int DEPTH = MAX_FRUSTA * cfc_pkg::PLANES_PER_FRUSTUM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = (MAX_FRUSTA > 1) ? $clog2(MAX_FRUSTA) : 1;
    localparam int CW    = $clog2(MAX_FRUSTA + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } t_state;

    t_state r_state;

    logic [cfc_pkg::CNT_W-1:0]  r_cfg;
    logic [CW-1:0]              r_cnt;
    logic [AW-1:0]              r_addr;
    logic [FW-1:0]              r_fk;
    logic [cfc_pkg::SLOT_W-1:0] r_pl;
    logic [MAX_FRUSTA-1:0]      r_cull;
    logic [cfc_pkg::MASK_W-1:0] r_mask;
    logic signed [cfc_pkg::COORD_W-1:0] r_cx, r_cy, r_cz, r_rad;
    cfc_pkg::t_eval_ctl         r_rd_ctl;
    logic [FW-1:0]              r_rd_fk;
    logic                       r_out_valid;
    logic [cfc_pkg::MASK_W-1:0] r_out_mask;

    logic                       in_acc;
    logic                       load_ok;
    logic [AW-1:0]              waddr;
    logic [CW-1:0]              cnt_eff;
    logic                       issue;
    logic                       issue_last;
    logic                       out_free;
    cfc_pkg::t_plane            wdata;
    cfc_pkg::t_plane            rdata;
    cfc_pkg::t_eval_ctl         res_ctl;
    logic [FW-1:0]              res_fk;
    logic                       res_cull;
    logic [MAX_FRUSTA-1:0]      n_cull;
    logic [cfc_pkg::MASK_W-1:0] n_mask;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            r_cfg <= i_cfg.active_frustum_count;
        end
    end

    assign cnt_eff = (32'(r_cfg) > MAX_FRUSTA) ? CW'(MAX_FRUSTA) : CW'(r_cfg);

    // Input side
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign load_ok    = in_acc && (i_in.mode == cfc_pkg::MODE_LOAD)
                      && (i_in.plane_slot < cfc_pkg::SLOT_W'(cfc_pkg::PLANES_PER_FRUSTUM))
                      && (32'(i_in.frustum_slot) < MAX_FRUSTA);
    assign waddr      = AW'((32'(i_in.frustum_slot) << 2) + (32'(i_in.frustum_slot) << 1)
                      + 32'(i_in.plane_slot));
    assign wdata      = '{nx: i_in.coord_x, ny: i_in.coord_y, nz: i_in.coord_z,
                          d: i_in.coord_w};

    assign issue      = (r_state == S_ISSUE);
    assign issue_last = (r_pl == cfc_pkg::LAST_PLANE) && (32'(r_fk) + 1 == 32'(r_cnt));

    cfc_plane_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    cfc_plane_eval #(
        .FW (FW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_fk    (r_rd_fk),
        .i_plane (rdata),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_cz    (r_cz),
        .i_rad   (r_rad),
        .o_ctl   (res_ctl),
        .o_fk    (res_fk),
        .o_cull  (res_cull)
    );

    // Fold the arriving plane result into the per-frustum cull flags
    always_comb begin
        n_cull = r_cull;
        if (res_ctl.valid && res_cull) begin
            n_cull[res_fk] = 1'b1;
        end
        n_mask = r_mask;
        for (int k = 0; k < MAX_FRUSTA; k++) begin
            if (k < 32'(r_cnt)) begin
                n_mask[k] = !n_cull[k];
            end
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ctl <= '{valid: issue, last: issue_last};
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_mask  <= r_mask;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.mode == cfc_pkg::MODE_TEST && cnt_eff != '0) begin
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ISSUE: begin
                    if (issue_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (res_ctl.valid && res_ctl.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_fk <= r_fk;
        r_cull  <= in_acc ? '0 : n_cull;
        if (in_acc) begin
            r_cx   <= i_in.coord_x;
            r_cy   <= i_in.coord_y;
            r_cz   <= i_in.coord_z;
            r_rad  <= i_in.coord_w;
            r_mask <= i_in.prior_mask;
            r_cnt  <= cnt_eff;
            r_addr <= '0;
            r_fk   <= '0;
            r_pl   <= '0;
        end else if (issue) begin
            r_addr <= r_addr + AW'(1);
            if (r_pl == cfc_pkg::LAST_PLANE) begin
                r_pl <= '0;
                r_fk <= r_fk + FW'(1);
            end else begin
                r_pl <= r_pl + cfc_pkg::SLOT_W'(1);
            end
        end else if (r_state == S_WAIT && res_ctl.valid && res_ctl.last) begin
            r_mask <= n_mask;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.new_mask = r_out_mask;

endmodule

FILE: rtl/cfc_checker.sv
// ----------------------------------------------------------------------------
// cfc_checker
// Port-level checks for the culling core, bound to the top level.
// ----------------------------------------------------------------------------
module cfc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cfc_pkg::MASK_W-1:0] i_out_mask
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_mask))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result item without an item in work");

endmodule

bind sphere_frustum_cull_core cfc_checker u_cfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mask  (o_out.new_mask)
);
